FILE: rtl/sbie_pkg.sv
// Shared types, opcodes and constants for the sixteen-bit instruction executor.
`default_nettype none
package sbie_pkg;

  typedef struct packed {
    logic [15:0] instruction_word;
    logic [15:0] immediate_word;
  } in_req_t;

  typedef struct packed {
    logic [15:0] next_address;
    logic        used_immediate;
    logic [15:0] flags_value;
    logic [15:0] dest_value;
  } out_req_t;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_DIV  = 4'd3,
    OP_CMP  = 4'd4,
    OP_ADC  = 4'd5,
    OP_WMUL = 4'd6,
    OP_WDIV = 4'd7,
    OP_IMM  = 4'd15
  } opcode_e;

  localparam logic [3:0] SUB_LEA  = 4'd0;
  localparam logic [3:0] SUB_JUMP = 4'd3;
  localparam logic [3:0] FLAG_REG = 4'd15;
  localparam logic [15:0] MUL_LIMIT = 16'd32767;
  localparam logic [7:0]  CARRY_BITS = 8'd192;
  localparam int QUEUE_DEPTH = 2;
  localparam int QW = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } exec_state_e;

endpackage
`default_nettype wire

FILE: rtl/sbie_queue.sv
// Two-entry request queue between the front and back parts.
`default_nettype none
module sbie_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire sbie_pkg::in_req_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output sbie_pkg::in_req_t     out_data_o
);
  import sbie_pkg::*;

  in_req_t       mem_q [QUEUE_DEPTH];
  logic [QW-1:0] wp_q, rp_q;
  logic [QW:0]   cnt_q;
  logic          push, pop;

  assign in_ready_o  = (cnt_q != (QW+1)'(QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + QW'(1);
      if (pop) rp_q <= rp_q + QW'(1);
      cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QW+1)'(QUEUE_DEPTH)) else $error("queue overflow");
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - (QW+1)'(1)) else $error("pop count");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + (QW+1)'(1)) else $error("push count");
`endif

endmodule
`default_nettype wire

FILE: rtl/sbie_exec.sv
// Back part: register file, program counter, ALU and iterative divider.
`default_nettype none
module sbie_exec (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sbie_pkg::in_req_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sbie_pkg::out_req_t     out_data_o
);
  import sbie_pkg::*;

  exec_state_e state_q, state_d;
  logic [15:0] rf_q [16];
  logic [15:0] pc_q;
  in_req_t     ins_q;
  logic [15:0] a_q, b_q, f_q;
  logic [31:0] prod_q;
  logic [31:0] quo_q;
  logic [15:0] rem_q;
  logic [4:0]  cnt_q;
  logic        neg_q;
  out_req_t    out_q;
  logic        out_v_q;

  logic [3:0] op, d, sa, sb;
  assign op = ins_q.instruction_word[15:12];
  assign d  = ins_q.instruction_word[11:8];
  assign sa = ins_q.instruction_word[7:4];
  assign sb = ins_q.instruction_word[3:0];

  logic [3:0] i_sa, i_sb;
  assign i_sa = in_data_i.instruction_word[7:4];
  assign i_sb = in_data_i.instruction_word[3:0];

  logic accept;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept = in_valid_i && in_ready_o;
  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

  logic [16:0] rem_sh;
  logic [16:0] rem_try;
  assign rem_sh  = {rem_q, quo_q[31]};
  assign rem_try = rem_sh - {1'b0, b_q};

  // signed divide: 16 steps on magnitudes, then 16 steps for the unsigned remainder
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_MUL;
      ST_MUL: begin
        if ((op == OP_DIV || op == OP_WDIV) && b_q != '0) state_d = ST_DIV;
        else state_d = ST_DONE;
      end
      ST_DIV: begin
        if (op == OP_DIV && cnt_q == 5'd15) state_d = ST_FIX;
        else if (cnt_q == 5'd31) state_d = ST_DONE;
      end
      ST_FIX: state_d = ST_DIV;
      ST_DONE: if (!out_v_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  logic [15:0] wv [16];
  logic [16:0] sum;
  logic [15:0] res, fl, na, absa, absb, q16;
  logic        carry, ov;

  always_comb begin
    for (int k = 0; k < 16; k++) wv[k] = rf_q[k];
    sum = '0; res = '0; fl = f_q; carry = 1'b0; ov = 1'b0;
    na = pc_q + 16'd1;
    q16 = neg_q ? 16'(-prod_q[31:16]) : prod_q[31:16];
    case (op)
      OP_ADD, OP_ADC: begin
        sum = {1'b0, a_q} + {1'b0, b_q} + 17'((op == OP_ADC) & f_q[7]);
        res = sum[15:0];
        carry = sum[16];
        ov = (a_q[15] == b_q[15]) && (res[15] != a_q[15]);
        fl = {8'd0, carry ? CARRY_BITS : 8'd0} | {10'd0, ov, !ov && res[15],
             1'b0, res == '0, sum != '0, !(res[15] || ov)};
        wv[FLAG_REG] = fl; wv[d] = res;
      end
      OP_SUB: begin
        res = a_q - b_q;
        carry = a_q > b_q;
        ov = (a_q[15] == b_q[15]) && (res[15] != a_q[15]);
        fl = {8'd0, carry ? CARRY_BITS : 8'd0} | {10'd0, ov, !ov && res[15],
             1'b0, res == '0, 1'b1, !(res[15] || ov)};
        wv[FLAG_REG] = fl; wv[d] = res;
      end
      OP_MUL: begin
        wv[FLAG_REG] = {10'd0, prod_q > {16'd0, MUL_LIMIT}, 5'd0};
        wv[d] = prod_q[15:0];
      end
      OP_WMUL: begin
        wv[FLAG_REG] = prod_q[31:16]; wv[d] = prod_q[15:0];
      end
      OP_DIV: begin
        wv[FLAG_REG] = (b_q == '0) ? '0 : rem_q;
        wv[d] = (b_q == '0) ? '0 : q16;
      end
      OP_CMP: begin
        wv[FLAG_REG] = {11'd0, $signed(a_q) < $signed(b_q), a_q < b_q, a_q == b_q,
                        a_q > b_q, $signed(a_q) > $signed(b_q)};
      end
      OP_WDIV: begin
        wv[FLAG_REG] = (b_q == '0) ? '0 : quo_q[15:0];
        wv[d] = (b_q == '0) ? '0 : quo_q[31:16];
        wv[sa] = (b_q == '0) ? '0 : rem_q;
      end
      OP_IMM: begin
        na = pc_q + 16'd2;
        if (sb == SUB_LEA) wv[d] = a_q + ins_q.immediate_word;
        else if (sb == SUB_JUMP) na = a_q + ins_q.immediate_word;
      end
      default: ;
    endcase
    wv[0] = '0;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ins_q <= in_data_i;
      a_q <= (i_sa == '0) ? '0 : rf_q[i_sa];
      b_q <= (i_sb == '0) ? '0 : rf_q[i_sb];
      f_q <= rf_q[FLAG_REG];
    end
    case (state_q)
      ST_MUL: begin
        cnt_q <= '0;
        rem_q <= '0;
        if (op == OP_DIV) begin
          quo_q  <= {a_q[15] ? 16'(-a_q) : a_q, 16'd0};
          b_q    <= b_q[15] ? 16'(-b_q) : b_q;
          neg_q  <= a_q[15] ^ b_q[15];
          prod_q <= {a_q, b_q};
        end else begin
          quo_q  <= {f_q, a_q};
          neg_q  <= 1'b0;
          prod_q <= a_q * b_q;
        end
      end
      ST_DIV: begin
        cnt_q <= cnt_q + 5'd1;
        if (!rem_try[16]) begin
          rem_q <= rem_try[15:0];
          quo_q <= {quo_q[30:0], 1'b1};
        end else begin
          rem_q <= rem_sh[15:0];
          quo_q <= {quo_q[30:0], 1'b0};
        end
      end
      ST_FIX: begin
        quo_q  <= {a_q, 16'd0};
        b_q    <= prod_q[15:0];
        rem_q  <= '0;
        prod_q <= {quo_q[15:0], prod_q[15:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      out_v_q <= 1'b0;
      for (int k = 0; k < 16; k++) rf_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (state_q == ST_DONE && (!out_v_q || out_ready_i)) begin
        for (int k = 0; k < 16; k++) rf_q[k] <= wv[k];
        pc_q <= na;
        out_v_q <= 1'b1;
        out_q.next_address <= na;
        out_q.used_immediate <= (op == OP_IMM);
        out_q.flags_value <= wv[FLAG_REG];
        out_q.dest_value <= wv[d];
      end
    end
  end

`ifndef SYNTHESIS
  a_r0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_q[0] == '0) else $error("r0 written");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_MUL) else $error("bad start");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> out_v_q && $stable(out_q)) else $error("out drop");
`endif

endmodule
`default_nettype wire

FILE: rtl/sixteen_bit_instruction_executor_top.sv
// Path: request queue, then the back end's ST_MUL state, divide passes for divides
// by a nonzero divisor, and ST_DONE, which registers the result once the output is free.
// The back end takes one instruction at a time; signed divide makes two 16-step
// passes and wide divide one 32-step pass, while the queue holds up to two requests.
// Reset (async, active low) clears registers, program counter and queue.
// Top level: request queue feeding the execution back end.
`default_nettype none
module sixteen_bit_instruction_executor_top (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sbie_pkg::in_req_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sbie_pkg::out_req_t     out_data_o
);
  import sbie_pkg::*;

  in_req_t q_data;
  logic    q_valid, q_ready;

  sbie_queue u_queue (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o(q_valid), .out_ready_i(q_ready), .out_data_o(q_data)
  );

  sbie_exec u_exec (
    .clk_i, .rst_ni, .in_valid_i(q_valid), .in_ready_o(q_ready), .in_data_i(q_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench for the sixteen-bit instruction executor: random and directed requests, scoreboard check.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sbie_pkg::*;

  class exec_scoreboard;
    logic [15:0] regs [16];
    logic [15:0] pc;
    out_req_t pending [$];
    int mismatches;
    int checked;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc = '0;
      mismatches = 0;
      checked = 0;
    endfunction

    function logic [15:0] rd(logic [3:0] id);
      return (id == 4'd0) ? 16'h0 : regs[id];
    endfunction

    function void wr(logic [3:0] id, logic [15:0] v);
      if (id != 4'd0) regs[id] = v;
    endfunction

    function logic [15:0] add_flags(bit carry, logic [15:0] a, logic [15:0] b,
                                    logic [15:0] r, bit nz);
      bit ov;
      logic [15:0] f;
      ov = (a[15] == b[15]) && (r[15] != a[15]);
      f = '0;
      f[7] = carry;
      f[6] = carry;
      f[5] = ov;
      f[4] = !ov && r[15];
      f[2] = (r == 16'h0);
      f[1] = nz;
      f[0] = !(r[15] || ov);
      return f;
    endfunction

    function void note_request(in_req_t req);
      logic [3:0] op, d, sa, sb;
      logic [15:0] a, b, r, ma, mb, q;
      logic [16:0] s;
      logic [31:0] p, dvd, wq;
      logic [15:0] f;
      out_req_t e;
      op = req.instruction_word[15:12];
      d  = req.instruction_word[11:8];
      sa = req.instruction_word[7:4];
      sb = req.instruction_word[3:0];
      a = rd(sa);
      b = rd(sb);
      pc = pc + 16'd1;
      e.used_immediate = 1'b0;
      case (op)
        OP_ADD, OP_ADC: begin
          f = rd(FLAG_REG);
          s = {1'b0, a} + {1'b0, b} + ((op == OP_ADC) ? {16'h0, f[7]} : 17'h0);
          wr(FLAG_REG, add_flags(s[16], a, b, s[15:0], s != 17'h0));
          wr(d, s[15:0]);
        end
        OP_SUB: begin
          r = a - b;
          wr(FLAG_REG, add_flags(a > b, a, b, r, 1'b1));
          wr(d, r);
        end
        OP_MUL: begin
          p = a * b;
          f = '0;
          f[5] = p > 32'd32767;
          wr(FLAG_REG, f);
          wr(d, p[15:0]);
        end
        OP_DIV: begin
          if (b != 16'h0) begin
            ma = a[15] ? -a : a;
            mb = b[15] ? -b : b;
            q = ma / mb;
            if (a[15] ^ b[15]) q = -q;
            wr(FLAG_REG, a % b);
            wr(d, q);
          end else begin
            wr(FLAG_REG, 16'h0);
            wr(d, 16'h0);
          end
        end
        OP_CMP: begin
          f = '0;
          f[0] = $signed(a) > $signed(b);
          f[1] = a > b;
          f[2] = a == b;
          f[3] = a < b;
          f[4] = $signed(a) < $signed(b);
          wr(FLAG_REG, f);
        end
        OP_WMUL: begin
          p = a * b;
          wr(FLAG_REG, p[31:16]);
          wr(d, p[15:0]);
        end
        OP_WDIV: begin
          if (b != 16'h0) begin
            dvd = {rd(FLAG_REG), a};
            wq = dvd / b;
            wr(FLAG_REG, wq[15:0]);
            wr(d, wq[31:16]);
            wr(sa, 16'(dvd % b));
          end else begin
            wr(FLAG_REG, 16'h0);
            wr(d, 16'h0);
            wr(sa, 16'h0);
          end
        end
        OP_IMM: begin
          e.used_immediate = 1'b1;
          pc = pc + 16'd1;
          if (sb == SUB_LEA) wr(d, a + req.immediate_word);
          else if (sb == SUB_JUMP) pc = a + req.immediate_word;
        end
        default: ;
      endcase
      e.next_address = pc;
      e.flags_value = rd(FLAG_REG);
      e.dest_value = rd(d);
      pending.push_back(e);
    endfunction

    function bit check_result(out_req_t got);
      out_req_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return 0;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: pc %h/%h imm %b/%b flags %h/%h dest %h/%h (exp/act)",
                   e.next_address, got.next_address, e.used_immediate,
                   got.used_immediate, e.flags_value, got.flags_value,
                   e.dest_value, got.dest_value);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_req_t in_data;
  out_req_t out_data;
  exec_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  int stall_cycles;
  int sent;

  sixteen_bit_instruction_executor_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (out_valid && out_ready) void'(sb.check_result(out_data));
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays up after acceptance until the next request or drain takes over
  task automatic send(logic [15:0] ins, logic [15:0] imm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= '{instruction_word: ins, immediate_word: imm};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(in_data);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [15:0] mk(logic [3:0] op, logic [3:0] d,
                                     logic [3:0] a, logic [3:0] b);
    return {op, d, a, b};
  endfunction

  function automatic logic [15:0] edge_val();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h8000;
      3: return 16'h7fff;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [3:0] op, d, a, b;
    repeat (n) begin
      case ($urandom_range(9))
        0: begin
          d = 4'($urandom_range(1, 14));
          send(mk(OP_IMM, d, 4'd0, SUB_LEA), edge_val());
        end
        default: begin
          op = 4'($urandom);
          d = 4'($urandom);
          a = 4'($urandom);
          b = 4'($urandom);
          send(mk(op, d, a, b), 16'($urandom));
        end
      endcase
    end
  endtask

  initial begin : watchdog
    stall_cycles = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (stall_cycles > 5000) begin
        $display("sixteen_bit_instruction_executor_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] corner [5];
    sb = new();
    sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    corner = '{16'h0000, 16'hffff, 16'h8000, 16'h7fff, 16'h0001};
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: load corners then every opcode
    for (int i = 0; i < 5; i++)
      send(mk(OP_IMM, 4'(i + 1), 4'd0, SUB_LEA), corner[i]);
    send(mk(OP_ADD, 4'd6, 4'd2, 4'd5), 16'h0);
    send(mk(OP_ADC, 4'd7, 4'd2, 4'd2), 16'h0);
    send(mk(OP_SUB, 4'd8, 4'd3, 4'd5), 16'h0);
    send(mk(OP_MUL, 4'd9, 4'd2, 4'd2), 16'h0);
    send(mk(OP_DIV, 4'd9, 4'd3, 4'd2), 16'h0);
    send(mk(OP_DIV, 4'd9, 4'd3, 4'd0), 16'h0);
    send(mk(OP_CMP, 4'd1, 4'd3, 4'd4), 16'h0);
    send(mk(OP_WMUL, 4'd10, 4'd2, 4'd2), 16'h0);
    send(mk(OP_WDIV, 4'd11, 4'd2, 4'd5), 16'h0);
    send(mk(OP_WDIV, 4'd11, 4'd2, 4'd0), 16'h0);
    send(mk(OP_ADD, 4'd0, 4'd2, 4'd2), 16'h0);
    send(mk(4'd9, 4'd2, 4'd2, 4'd2), 16'hffff);
    send(mk(OP_IMM, 4'd1, 4'd2, 4'd7), 16'h1234);
    send(mk(OP_IMM, 4'd0, 4'd2, SUB_JUMP), 16'h0001);
    send(mk(OP_IMM, 4'd0, 4'd0, SUB_JUMP), 16'hfffe);
    send(mk(OP_ADD, 4'd15, 4'd2, 4'd2), 16'hffff);
    // wait for everything before the random part
    drain();

    send_idle_pct = 33; recv_idle_pct = 63;
    random_phase(360);
    send_idle_pct = 63; recv_idle_pct = 33;
    random_phase(360);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(360);
    drain();

    $display("ran %0d requests over all opcodes, %0d results checked", sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("sixteen_bit_instruction_executor_top regression: pass");
    else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.pending.size());
      $display("sixteen_bit_instruction_executor_top regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
rtl/sbie_pkg.sv
rtl/sbie_queue.sv
rtl/sbie_exec.sv
rtl/sixteen_bit_instruction_executor_top.sv
tb/sv/tb_top.sv
